[sv/scf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scf_pkg: shared types and constants of the subtour cycle finder
// Widths, capacity, controller states, command/status bundles and bit search
// helpers used by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package scf_pkg;

   localparam int MAX_LOCATIONS = 32;
   localparam int CAPACITY      = (MAX_LOCATIONS < 32) ? MAX_LOCATIONS : 32;

   localparam int ROW_W    = 32;
   localparam int NODE_W   = 5;
   localparam int COUNT_W  = 6;
   localparam int DEPTH    = 32;
   localparam int RSP_W    = 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_VISIT,
      S_LINK,
      S_EMIT_RD,
      S_EMIT_LD,
      S_HOLD
   } scf_state_type;

   typedef struct packed {
      logic load;
      logic init_walk;
      logic visit;
      logic link;
      logic emit_load;
      logic emit_next;
      logic finish;
   } scf_cmd_type;

   typedef struct packed {
      logic chain_end;
      logic walk_done;
      logic held_last;
   } scf_sts_type;

   function automatic logic [NODE_W-1:0] highest_bit(input logic [ROW_W-1:0] v);
      logic [NODE_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (v[i]) idx = NODE_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [NODE_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
      logic [NODE_W-1:0] idx;
      idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) idx = NODE_W'(i);
      end
      return idx;
   endfunction

endpackage

[sv/scf_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scf_ctrl: sequencing controller of the subtour cycle finder
// Accepts rows while idle, then steps the datapath through the cycle walk
// and the emission of the stored subtour nodes.
// ---------------------------------------------------------------------------
module scf_ctrl import scf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  scf_sts_type sts,
   output scf_cmd_type cmd
);

   scf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) state_in = S_START;
            end
         end
         S_START: begin
            cmd.init_walk = 1'b1;
            state_in      = S_VISIT;
         end
         S_VISIT: begin
            cmd.visit = 1'b1;
            state_in  = S_LINK;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            // an empty member set also lands here once and ends at once
            if (sts.chain_end && sts.walk_done) state_in = S_EMIT_RD;
            else                                state_in = S_VISIT;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = S_HOLD;
         end
         S_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.held_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/scf_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scf_datapath: storage and walk logic of the subtour cycle finder
// Holds the successor memory, member mask and chain buffer, follows
// successors node by node and forms the result items.
// ---------------------------------------------------------------------------
module scf_datapath import scf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scf_cmd_type       cmd,
   output scf_sts_type       sts,
   input  logic [ROW_W-1:0]  row_bits,
   output logic [NODE_W-1:0] node,
   output logic              subtour_end,
   output logic              found,
   output logic              overflow,
   output logic              last
);

   logic [NODE_W-1:0]  succ_mem [DEPTH];
   logic [NODE_W:0]    chain_mem [DEPTH];

   logic [ROW_W-1:0]   member_ff, member_in;
   logic [COUNT_W-1:0] row_count_ff, row_count_in;
   logic               overflow_ff, overflow_in;
   logic [ROW_W-1:0]   unvisited_ff, unvisited_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic               first_ff, first_in;
   logic               nosub_ff, nosub_in;
   logic [NODE_W-1:0]  idx_ff, idx_in;
   logic [NODE_W-1:0]  succ_rd_ff;
   logic [NODE_W:0]    chain_rd_ff;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               end_ff, end_in;
   logic               found_ff, found_in;
   logic               ovf_out_ff, ovf_out_in;
   logic               last_ff, last_in;

   logic               row_fits;
   logic               row_single;
   logic               chain_end;
   logic               walk_done;
   logic               is_last;

   assign row_fits   = row_count_ff < COUNT_W'(CAPACITY);
   // exactly one bit set
   assign row_single = (row_bits != '0) && ((row_bits & (row_bits - ROW_W'(1))) == '0);
   assign chain_end  = !unvisited_ff[succ_rd_ff];
   assign walk_done  = (unvisited_ff == '0);
   assign is_last    = nosub_ff || ((COUNT_W'(idx_ff) + COUNT_W'(1)) == len_ff);

   assign sts.chain_end = chain_end || nosub_ff;
   assign sts.walk_done = walk_done;
   assign sts.held_last = last_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load && row_fits) begin
         succ_mem[row_count_ff[NODE_W-1:0]] <= highest_bit(row_bits);
      end
      if (cmd.link && !nosub_ff) begin
         chain_mem[len_ff[NODE_W-1:0]] <= {cur_ff, chain_end};
      end
      succ_rd_ff  <= succ_mem[cur_ff];
      chain_rd_ff <= chain_mem[idx_ff];
   end

   always_comb begin
      member_in    = member_ff;
      row_count_in = row_count_ff;
      overflow_in  = overflow_ff;
      unvisited_in = unvisited_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      nosub_in     = nosub_ff;
      idx_in       = idx_ff;
      node_in      = node_ff;
      end_in       = end_ff;
      found_in     = found_ff;
      ovf_out_in   = ovf_out_ff;
      last_in      = last_ff;

      if (cmd.load) begin
         if (row_fits) begin
            if (row_single) begin
               member_in = member_ff | (ROW_W'(1) << row_count_ff[NODE_W-1:0]);
            end
            row_count_in = row_count_ff + COUNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cmd.init_walk) begin
         unvisited_in = member_ff;
         cur_in       = lowest_bit(member_ff);
         len_in       = '0;
         first_in     = 1'b1;
         nosub_in     = (member_ff == '0);
         idx_in       = '0;
      end

      if (cmd.visit) begin
         unvisited_in = unvisited_ff & ~(ROW_W'(1) << cur_ff);
      end

      if (cmd.link && !nosub_ff) begin
         len_in = len_ff + COUNT_W'(1);
         if (chain_end) begin
            // a first chain that covers every member is the whole tour
            if (first_ff && walk_done) nosub_in = 1'b1;
            first_in = 1'b0;
            cur_in   = lowest_bit(unvisited_ff);
         end else begin
            cur_in = succ_rd_ff;
         end
      end

      if (cmd.emit_load) begin
         node_in    = nosub_ff ? '0 : chain_rd_ff[NODE_W:1];
         end_in     = nosub_ff ? 1'b0 : chain_rd_ff[0];
         found_in   = !nosub_ff;
         ovf_out_in = overflow_ff;
         last_in    = is_last;
      end

      if (cmd.emit_next) begin
         idx_in = idx_ff + NODE_W'(1);
      end

      if (cmd.finish) begin
         member_in    = '0;
         row_count_in = '0;
         overflow_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         member_ff    <= '0;
         row_count_ff <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         member_ff    <= member_in;
         row_count_ff <= row_count_in;
         overflow_ff  <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      unvisited_ff <= unvisited_in;
      cur_ff       <= cur_in;
      len_ff       <= len_in;
      first_ff     <= first_in;
      nosub_ff     <= nosub_in;
      idx_ff       <= idx_in;
      node_ff      <= node_in;
      end_ff       <= end_in;
      found_ff     <= found_in;
      ovf_out_ff   <= ovf_out_in;
      last_ff      <= last_in;
   end

   assign node        = node_ff;
   assign subtour_end = end_ff;
   assign found       = found_ff;
   assign overflow    = ovf_out_ff;
   assign last        = last_ff;

endmodule

[sv/subtour_cycle_finder_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// subtour_cycle_finder_core: subtour detection by cycle decomposition
// Loads a 0/1 departure matrix row by row, then splits the single-exit rows
// into successor chains and streams out every chain shorter than the tour.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                     tuser   tlast
//  req_     in   row_bits[31:0]                            -       last_row
//  rsp_     out  node[4:0] subtour_end[5] overflow[6] 0[7]  found   last
//
//  rows are taken one per cycle while no search runs
//  the search visits each member node with a successor memory read, then a
//  chain buffer write, after a start-up step; an empty member set still
//  takes one visit
//  each result item then passes through a chain buffer read, an output load and a hold until rsp_tready
//  reset is synchronous; it empties the member set, row count and overflow
// ---------------------------------------------------------------------------
module subtour_cycle_finder_core import scf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ROW_W-1:0] req_tdata,   // row_bits[31:0]
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // node[4:0], subtour_end[5], overflow[6], zero[7]
   output logic             rsp_tuser,   // found
   output logic             rsp_tlast
);

   scf_cmd_type       cmd;
   scf_sts_type       sts;
   logic [NODE_W-1:0] node;
   logic              subtour_end;
   logic              overflow;

   scf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   scf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .row_bits    (req_tdata),
      .node        (node),
      .subtour_end (subtour_end),
      .found       (rsp_tuser),
      .overflow    (overflow),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, overflow, subtour_end, node};

endmodule

[tb/subtour_cycle_finder_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// subtour_cycle_finder_core_tb: self-checking bench for the subtour finder
// Streams departure matrices row by row. A scoreboard predicts the reported
// subtour nodes and compares them with every result item. Traffic includes
// permutations, single tours, split tours, noisy rows and oversize matrices,
// under several sender and receiver stall patterns.
// ---------------------------------------------------------------------------
module subtour_cycle_finder_core_tb import scf_pkg::*; ();

   localparam int END_BIT     = 5;
   localparam int OVF_BIT     = 6;
   localparam int PAD_BIT     = 7;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 200;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              tour_end;
      logic              found;
      logic              ovf;
      logic              is_last;
   } subtour_item_type;

   class cycle_scoreboard_type;
      logic [NODE_W-1:0] succ_node [DEPTH];
      logic [31:0]       member_set;
      int unsigned       rows_loaded;
      logic              dropped_rows;
      subtour_item_type  expected_q [$];
      int                errors;
      int                searches;
      int                subtours;
      int                tourless;
      int                clipped;
      int                results;

      function new();
         for (int k = 0; k < DEPTH; k++) succ_node[k] = '0;
         member_set   = '0;
         rows_loaded  = 0;
         dropped_rows = 1'b0;
         errors       = 0;
         searches     = 0;
         subtours     = 0;
         tourless     = 0;
         clipped      = 0;
         results      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // split the member set into successor chains and queue the short ones
      function void search_subtours();
         logic [31:0]       open_set;
         logic [NODE_W-1:0] chain [32];
         logic [NODE_W-1:0] nxt;
         int                total;
         int                len;
         int                cur;
         int                emitted;
         subtour_item_type  it;
         open_set = member_set;
         total    = $countones(member_set);
         emitted  = 0;
         while (open_set != 0) begin
            cur = 0;
            while (!open_set[cur]) cur++;
            len = 0;
            forever begin
               chain[len] = NODE_W'(cur);
               len++;
               open_set[cur] = 1'b0;
               nxt = succ_node[cur];
               if (!open_set[nxt]) break;
               cur = nxt;
            end
            if (len < total) begin
               for (int i = 0; i < len; i++) begin
                  it.node     = chain[i];
                  it.tour_end = (i == len - 1);
                  it.found    = 1'b1;
                  it.ovf      = dropped_rows;
                  it.is_last  = 1'b0;
                  expected_q.insert(expected_q.size(), it);
                  emitted++;
               end
               subtours++;
            end
         end
         if (emitted == 0) begin
            it         = '0;
            it.ovf     = dropped_rows;
            it.is_last = 1'b1;
            expected_q.insert(expected_q.size(), it);
            tourless++;
         end else begin
            it = expected_q.pop_back();
            it.is_last = 1'b1;
            expected_q.insert(expected_q.size(), it);
         end
         if (dropped_rows) clipped++;
         searches++;
         member_set   = '0;
         rows_loaded  = 0;
         dropped_rows = 1'b0;
      endfunction

      function void note_row(logic [ROW_W-1:0] bits, logic final_row);
         logic [NODE_W-1:0] hi;
         if (rows_loaded < CAPACITY) begin
            hi = '0;
            for (int j = 0; j < ROW_W; j++) begin
               if (bits[j]) hi = NODE_W'(j);
            end
            succ_node[rows_loaded] = hi;
            if ($countones(bits) == 1) member_set[rows_loaded] = 1'b1;
            rows_loaded++;
         end else begin
            dropped_rows = 1'b1;
         end
         if (final_row) search_subtours();
      endfunction

      function void check_result(logic [RSP_W-1:0] data, logic user, logic tl);
         subtour_item_type want;
         results++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result item, data=%h found=%b last=%b",
                     $time, data, user, tl);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (data[NODE_W-1:0] !== want.node) begin
            $display("%0t: node mismatch, expected %0d, got %0d",
                     $time, want.node, data[NODE_W-1:0]);
            errors++;
         end
         if (data[END_BIT] !== want.tour_end) begin
            $display("%0t: subtour_end mismatch, expected %b, got %b",
                     $time, want.tour_end, data[END_BIT]);
            errors++;
         end
         if (data[OVF_BIT] !== want.ovf) begin
            $display("%0t: overflow mismatch, expected %b, got %b",
                     $time, want.ovf, data[OVF_BIT]);
            errors++;
         end
         if (data[PAD_BIT] !== 1'b0) begin
            $display("%0t: pad bit mismatch, expected 0, got %b", $time, data[PAD_BIT]);
            errors++;
         end
         if (user !== want.found) begin
            $display("%0t: found mismatch, expected %b, got %b", $time, want.found, user);
            errors++;
         end
         if (tl !== want.is_last) begin
            $display("%0t: last mismatch, expected %b, got %b", $time, want.is_last, tl);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ROW_W-1:0] req_tdata = '0;   // row_bits[31:0]
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // node[4:0], subtour_end[5], overflow[6], zero[7]
   logic             rsp_tuser;        // found
   logic             rsp_tlast;

   cycle_scoreboard_type sb = new();
   logic [ROW_W-1:0] row_list [$];
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               rows_sent = 0;
   int               quiet_cycles = 0;

   subtour_cycle_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_row(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // entered and left at a falling edge; valid stays up between back-to-back rows
   task automatic send_row(input logic [ROW_W-1:0] bits, input logic final_row);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tlast  <= final_row;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      rows_sent++;
   endtask

   task automatic send_matrix();
      for (int i = 0; i < row_list.size(); i++) send_row(row_list[i], i == row_list.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [ROW_W-1:0] noise_row();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) return 32'h1 << $urandom_range(31);
      if (pick < 70) return '0;
      return $urandom;
   endfunction

   // size 0 picks a random size, mostly small
   task automatic build_matrix(input int size);
      int          n;
      int          m;
      int          sel;
      int          kind;
      int          cut;
      int          tmp;
      int          idx;
      int          nxt;
      int          order [32];
      logic [31:0] mat [32];
      n = size;
      if (n == 0) begin
         sel = $urandom_range(99);
         if (sel < 60) n = $urandom_range(6, 2);
         else if (sel < 85) n = $urandom_range(16, 7);
         else if (sel < 95) n = 32;
         else n = $urandom_range(36, 33);
      end
      m = (n > CAPACITY) ? CAPACITY : n;
      for (int i = 0; i < m; i++) order[i] = i;
      for (int i = m - 1; i > 0; i--) begin
         idx        = $urandom_range(i);
         tmp        = order[i];
         order[i]   = order[idx];
         order[idx] = tmp;
      end
      kind = $urandom_range(99);
      cut  = $urandom_range(m - 1, 1);
      for (int k = 0; k < m; k++) begin
         if (kind < 35) begin
            mat[k] = 32'h1 << order[k];
         end else if (kind < 55) begin
            mat[order[k]] = 32'h1 << order[(k + 1) % m];
         end else if (kind < 80) begin
            // two successor loops split at cut
            if (k < cut) nxt = (k + 1 < cut) ? order[k + 1] : order[0];
            else nxt = (k + 1 < m) ? order[k + 1] : order[cut];
            mat[order[k]] = 32'h1 << nxt;
         end else begin
            mat[k] = noise_row();
         end
      end
      // break a well-formed matrix now and then
      if (kind < 80 && $urandom_range(99) < 15) begin
         idx = $urandom_range(m - 1);
         mat[idx] = $urandom_range(1) ? '0 : (mat[idx] | (32'h1 << $urandom_range(31)));
      end
      row_list.delete();
      for (int i = 0; i < m; i++) row_list.insert(row_list.size(), mat[i]);
      for (int i = m; i < n; i++) row_list.insert(row_list.size(), noise_row());
   endtask

   initial begin
      int quota;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed matrices
      row_list = '{32'h0000_0001};
      send_matrix();
      row_list = '{32'h0000_0002, 32'h0000_0001};
      send_matrix();
      row_list = '{32'h0000_0001, 32'h0000_0002};
      send_matrix();
      row_list = '{32'h0000_0002, 32'h0000_0004, 32'h0000_0001, 32'h0000_0010,
                   32'h0000_0008};
      send_matrix();
      row_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0008,
                   32'h0000_0004};
      send_matrix();
      row_list = '{32'h0010_0000, 32'h0000_0001, 32'h0000_0002};
      send_matrix();
      row_list = '{32'h8000_0000, 32'h0000_0002};
      send_matrix();
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         quota = rows_sent + 30;
         // phase 0 opens with a full-size matrix and phase 1 with an oversize one
         if (phase == 0) build_matrix(CAPACITY);
         else if (phase == 1) build_matrix($urandom_range(36, CAPACITY + 1));
         else build_matrix(0);
         send_matrix();
         while (rows_sent < quota) begin
            build_matrix(0);
            send_matrix();
         end
         wait_drained();
      end

      rsp_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d rows in %0d searches: %0d subtours, %0d without subtour",
               rows_sent, sb.searches, sb.subtours, sb.tourless);
      $display("%0d result items checked, %0d searches saw dropped rows",
               sb.results, sb.clipped);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
